[design/tss_pkg.sv]
// Shared types, codes and constants for the two-stack shared memory block.
// No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 11;
  localparam int CAP_RST   = 1024;

  localparam logic [2:0] FUNC_PUSH1 = 3'd0;
  localparam logic [2:0] FUNC_PUSH2 = 3'd1;
  localparam logic [2:0] FUNC_POP1  = 3'd2;
  localparam logic [2:0] FUNC_POP2  = 3'd3;
  localparam logic [2:0] FUNC_PEEK1 = 3'd4;
  localparam logic [2:0] FUNC_PEEK2 = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic                     first_empty;
    logic                     second_empty;
  } out_t;

  // Result of one transfer waiting for the memory read data.
  typedef struct packed {
    logic       use_mem;
    logic [1:0] status;
    logic       first_empty;
    logic       second_empty;
  } pend_t;

endpackage

[design/tss_ram.sv]
// Single-port synchronous slot memory, registered read data.
// Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_ram #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [tss_pkg::DATA_W-1:0] wdata,
  output logic [tss_pkg::DATA_W-1:0] rdata
);

  logic [tss_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[design/tss_ctrl.sv]
// Stack pointers, capacity register, memory addressing and the pending stage.
// Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_ctrl #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tss_pkg::in_t                in_data,
  input  logic                        cfg_we,
  input  logic [tss_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                        take,
  output logic                        pend_vld,
  output tss_pkg::pend_t              pend,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_addr,
  output logic [tss_pkg::DATA_W-1:0]  mem_wdata
);

  localparam int CW = (CNT_W > tss_pkg::CAP_W) ? CNT_W : tss_pkg::CAP_W;
  localparam int CAP_RST_EFF = (tss_pkg::CAP_RST > DEPTH) ? DEPTH : tss_pkg::CAP_RST;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] MIN_C   = CW'(2);

  logic [CNT_W-1:0] cap_r, first_r, first_nxt, second_r, second_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  tss_pkg::pend_t   pend_r, pend_nxt;
  logic             in_acc, full;
  logic [CNT_W:0]   used;
  logic [CW-1:0]    cfg_ext, cfg_clamp;
  logic [CNT_W-1:0] addr_w;

  assign in_stall = pend_vld_r && !take;
  assign in_acc   = in_valid && !in_stall;
  assign used     = {1'b0, first_r} + {1'b0, second_r};
  assign full     = used >= {1'b0, cap_r};
  assign cfg_ext  = CW'(cfg_wdata);

  always_comb begin
    cfg_clamp = cfg_ext;
    if (cfg_ext < MIN_C) begin
      cfg_clamp = MIN_C;
    end else if (cfg_ext > DEPTH_C) begin
      cfg_clamp = DEPTH_C;
    end
  end

  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    addr_w     = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    pend_nxt.use_mem = 1'b0;
    pend_nxt.status  = tss_pkg::ST_OK;
    case (in_data.func)
      tss_pkg::FUNC_PUSH1: begin
        addr_w = first_r;
        if (full) begin
          pend_nxt.status = tss_pkg::ST_OVERFLOW;
        end else begin
          mem_we    = in_acc;
          first_nxt = first_r + 1'b1;
        end
      end
      tss_pkg::FUNC_PUSH2: begin
        addr_w = cap_r - 1'b1 - second_r;
        if (full) begin
          pend_nxt.status = tss_pkg::ST_OVERFLOW;
        end else begin
          mem_we     = in_acc;
          second_nxt = second_r + 1'b1;
        end
      end
      tss_pkg::FUNC_POP1, tss_pkg::FUNC_PEEK1: begin
        addr_w = first_r - 1'b1;
        if (first_r == '0) begin
          pend_nxt.status = tss_pkg::ST_EMPTY;
        end else begin
          mem_re           = in_acc;
          pend_nxt.use_mem = 1'b1;
          if (in_data.func == tss_pkg::FUNC_POP1) begin
            first_nxt = first_r - 1'b1;
          end
        end
      end
      tss_pkg::FUNC_POP2, tss_pkg::FUNC_PEEK2: begin
        addr_w = cap_r - second_r;
        if (second_r == '0) begin
          pend_nxt.status = tss_pkg::ST_EMPTY;
        end else begin
          mem_re           = in_acc;
          pend_nxt.use_mem = 1'b1;
          if (in_data.func == tss_pkg::FUNC_POP2) begin
            second_nxt = second_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    pend_nxt.first_empty  = (first_nxt == '0);
    pend_nxt.second_empty = (second_nxt == '0);
    if (!in_acc) begin
      first_nxt  = first_r;
      second_nxt = second_r;
    end
    pend_vld_nxt = in_acc || (pend_vld_r && !take);
  end

  assign mem_addr  = addr_w[AW-1:0];
  assign mem_wdata = in_data.push_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CNT_W'(CAP_RST_EFF);
      first_r    <= '0;
      second_r   <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      if (cfg_we) begin
        cap_r    <= cfg_clamp[CNT_W-1:0];
        first_r  <= '0;
        second_r <= '0;
      end else begin
        first_r  <= first_nxt;
        second_r <= second_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r <= pend_nxt;
    end
  end

  assign pend_vld = pend_vld_r;
  assign pend     = pend_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= {1'b0, cap_r})
    else $error("stack fill exceeds capacity");

  a_push1_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_we && in_data.func == tss_pkg::FUNC_PUSH1 && !full
    |=> first_r == $past(first_r) + 1'b1)
    else $error("push1 did not advance stack one");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r && !take |=> pend_vld_r && $stable(pend_r))
    else $error("pending result lost while output busy");

  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");

endmodule

[design/two_stacks_shared_memory.sv]
// Two LIFO stacks in one shared memory: top level with output register.
// Depends on tss_pkg, tss_ctrl, tss_ram.
// Path: an accepted input is registered in the pending stage (with its memory access), then in the output register.
// Throughput: one operation per cycle while the output is not stalled; at most one memory access per operation.
// Reset: both stacks empty, capacity 1024 (limited to DEPTH); memory not cleared.
// A capacity write empties both stacks.
`timescale 1ns / 1ps

module two_stacks_shared_memory #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tss_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tss_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [tss_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                       take, pend_vld, mem_we, mem_re;
  tss_pkg::pend_t             pend;
  logic [AW-1:0]              mem_addr;
  logic [tss_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
  logic                       out_valid_r;
  tss_pkg::out_t              out_r, out_nxt;

  tss_ctrl #(.DEPTH(DEPTH), .AW(AW), .CNT_W(CNT_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .pend_vld  (pend_vld),
    .pend      (pend),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  tss_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt.status       = pend.status;
    out_nxt.first_empty  = pend.first_empty;
    out_nxt.second_empty = pend.second_empty;
    if (pend.use_mem) begin
      out_nxt.read_value = mem_rdata;
    end else if (pend.status == tss_pkg::ST_EMPTY) begin
      out_nxt.read_value = '1;
    end else begin
      out_nxt.read_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= pend_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pend_vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
